@@ hw/rtl/cfrq_pkg.sv @@
// cfrq_pkg: shared types and codes for the checksum frame receiver queue.
// Used by cfrq_ctrl, cfrq_dp, the top level and the checker. No dependencies.
package cfrq_pkg;

  // input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // result kind codes
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // result status codes
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_IGNORED  = 3'd1;
  localparam logic [2:0] ST_QUEUED   = 3'd2;
  localparam logic [2:0] ST_BADSUM   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  // configuration register map (register index is paddr[2])
  localparam int          ADDR_W           = 3;
  localparam logic        REG_START_MARKER = 1'b0;
  localparam logic [7:0]  START_MARKER_RST = 8'hA5;

  typedef enum logic {
    CS_IDLE,
    CS_SEND
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;   // accepted received byte
    logic pop_empty;   // accepted pop, ring empty
    logic pop_start;   // accepted pop, fetch first byte of oldest frame
    logic send;        // move fetched byte into output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ring_empty;
    logic out_free;    // output register empty or being taken this cycle
    logic pop_done;    // byte being sent is the last of the frame
  } dp_status_t;

endpackage

@@ hw/rtl/cfrq_ctrl.sv @@
// cfrq_ctrl: sequencing state machine for the frame receiver queue.
// Depends on cfrq_pkg; drives commands into cfrq_dp.
module cfrq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_cmd,
  output logic                  in_stall,
  input  cfrq_pkg::dp_status_t  status,
  output cfrq_pkg::ctrl_cmd_t   cmd
);

  cfrq_pkg::ctrl_state_t state_r, state_nxt;
  logic                  accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfrq_pkg::CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    accept    = 1'b0;
    unique case (state_r)
      cfrq_pkg::CS_IDLE: begin
        in_stall = !status.out_free;
        accept   = in_valid && status.out_free;
        if (accept) begin
          if (in_cmd == cfrq_pkg::CMD_BYTE) begin
            cmd.take_byte = 1'b1;
          end else if (status.ring_empty) begin
            cmd.pop_empty = 1'b1;
          end else begin
            cmd.pop_start = 1'b1;
            state_nxt     = cfrq_pkg::CS_SEND;
          end
        end
      end
      cfrq_pkg::CS_SEND: begin
        if (status.out_free) begin
          cmd.send = 1'b1;
          if (status.pop_done) begin
            state_nxt = cfrq_pkg::CS_IDLE;
          end
        end
      end
      default: begin
        state_nxt = cfrq_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/cfrq_dp.sv @@
// cfrq_dp: datapath - frame gathering, checksum, slot memory, ring pointers,
// output register. Depends on cfrq_pkg; commanded by cfrq_ctrl.
module cfrq_dp #(
  parameter int FRAME_BYTES = 13,
  parameter int QUEUE_SLOTS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfrq_pkg::ctrl_cmd_t   cmd,
  output cfrq_pkg::dp_status_t  status,
  input  logic [7:0]            start_marker,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic [2:0]            out_status,
  output logic [7:0]            out_data_byte,
  output logic                  out_last,
  output logic                  out_link_active
);

  localparam int OW    = $clog2(FRAME_BYTES);       // byte offset in a slot
  localparam int CW    = $clog2(FRAME_BYTES + 1);   // read count incl. FRAME_BYTES
  localparam int SW    = $clog2(QUEUE_SLOTS);       // slot index
  localparam int AW    = SW + OW;
  localparam int DEPTH = 1 << AW;

  // frame gathering
  logic [OW-1:0] gc_r, gc_nxt;
  logic [7:0]    sum_r, sum_nxt;
  // ring pointers
  logic [SW-1:0] ws_r, ws_nxt, rs_r, rs_nxt, ws_inc, rs_inc;
  // pop burst
  logic [SW-1:0] pop_slot_r, pop_slot_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          link_hold_r, link_hold_nxt;
  // slot memory
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  // output register
  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt, out_last_r, out_last_nxt;
  logic          out_link_r, out_link_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic          load;
  // byte decode
  logic          ignore, ends, sum_ok, full;
  logic [2:0]    byte_status;
  logic          byte_link, pop_done;

  assign ws_inc = (ws_r == SW'(QUEUE_SLOTS - 1)) ? '0 : ws_r + 1'b1;
  assign rs_inc = (rs_r == SW'(QUEUE_SLOTS - 1)) ? '0 : rs_r + 1'b1;

  assign ignore   = (gc_r == '0) && (in_rx_byte != start_marker);
  assign ends     = !ignore && (gc_r == OW'(FRAME_BYTES - 1));
  assign sum_ok   = (sum_r == in_rx_byte);
  assign full     = (ws_inc == rs_r);
  assign pop_done = (rd_idx_r == CW'(FRAME_BYTES));

  always_comb begin
    if (ignore) begin
      byte_status = cfrq_pkg::ST_IGNORED;
    end else if (!ends) begin
      byte_status = cfrq_pkg::ST_ACCEPTED;
    end else if (!sum_ok) begin
      byte_status = cfrq_pkg::ST_BADSUM;
    end else if (full) begin
      byte_status = cfrq_pkg::ST_FULL;
    end else begin
      byte_status = cfrq_pkg::ST_QUEUED;
    end
  end

  // Bytes go straight into the free slot at ws_r; the slot only becomes
  // visible when ws_r advances on a good checksum.
  assign wr_en   = cmd.take_byte && !ignore;
  assign wr_addr = {ws_r, gc_r};
  assign rd_en   = cmd.pop_start || (cmd.send && !pop_done);
  assign rd_addr = cmd.pop_start ? {rs_r, OW'(0)} : {pop_slot_r, rd_idx_r[OW-1:0]};

  always_comb begin
    gc_nxt        = gc_r;
    sum_nxt       = sum_r;
    ws_nxt        = ws_r;
    rs_nxt        = rs_r;
    pop_slot_nxt  = pop_slot_r;
    rd_idx_nxt    = rd_idx_r;
    link_hold_nxt = link_hold_r;
    if (cmd.take_byte && !ignore) begin
      if (ends) begin
        gc_nxt  = '0;
        sum_nxt = '0;
        if (sum_ok && !full) begin
          ws_nxt = ws_inc;
        end
      end else begin
        gc_nxt  = gc_r + 1'b1;
        sum_nxt = sum_r + in_rx_byte;
      end
    end
    if (cmd.pop_start) begin
      rs_nxt        = rs_inc;
      pop_slot_nxt  = rs_r;
      rd_idx_nxt    = CW'(1);
      link_hold_nxt = (ws_r != rs_inc) || (gc_r != '0);
    end
    if (cmd.send && !pop_done) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
  end

  assign byte_link = (ws_nxt != rs_r) || (gc_nxt != '0);

  always_comb begin
    load           = 1'b1;
    out_kind_nxt   = cfrq_pkg::KIND_STATUS;
    out_status_nxt = cfrq_pkg::ST_ACCEPTED;
    out_data_nxt   = '0;
    out_last_nxt   = 1'b1;
    out_link_nxt   = byte_link;
    if (cmd.take_byte) begin
      out_status_nxt = byte_status;
    end else if (cmd.pop_empty) begin
      out_status_nxt = cfrq_pkg::ST_EMPTY;
      out_link_nxt   = (gc_r != '0);
    end else if (cmd.send) begin
      out_kind_nxt = cfrq_pkg::KIND_DATA;
      out_data_nxt = rd_data_r;
      out_last_nxt = pop_done;
      out_link_nxt = link_hold_r;
    end else begin
      load = 1'b0;
    end
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r        <= '0;
      sum_r       <= '0;
      ws_r        <= '0;
      rs_r        <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      gc_r        <= gc_nxt;
      sum_r       <= sum_nxt;
      ws_r        <= ws_nxt;
      rs_r        <= rs_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_slot_r  <= pop_slot_nxt;
    link_hold_r <= link_hold_nxt;
    if (load) begin
      out_kind_r   <= out_kind_nxt;
      out_status_r <= out_status_nxt;
      out_data_r   <= out_data_nxt;
      out_last_r   <= out_last_nxt;
      out_link_r   <= out_link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign status.ring_empty = (ws_r == rs_r);
  assign status.out_free   = !out_valid_r || !out_stall;
  assign status.pop_done   = pop_done;

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_data_byte   = out_data_r;
  assign out_last        = out_last_r;
  assign out_link_active = out_link_r;

endmodule

@@ hw/rtl/checksum_frame_receiver_queue_core.sv @@
// checksum_frame_receiver_queue_core: top level of the frame receiver queue.
// Depends on cfrq_pkg, cfrq_ctrl and cfrq_dp.
//
// Usage notes
// - Input channel (in_valid/in_stall, in_cmd, in_rx_byte): in_cmd BYTE hands
//   in one received byte; in_cmd POP asks for the oldest stored frame.
// - Output channel (out_valid/out_stall): each transaction is one result.
//   A byte or an empty pop gives one status result (out_last set). A pop of
//   a stored frame gives FRAME_BYTES data results, out_last on the final one.
// - Timing: a status result is in the output register the cycle after the
//   input transaction; a pop's first data byte goes via the slot memory
//   read register. Byte commands sustain one per cycle while out_stall is
//   low. A stored-frame pop holds in_stall high until its last byte is sent,
//   one byte per cycle through the single read port while out_stall is low.
// - out_stall freezes the output register; in_stall rises until the held
//   result is taken, and a burst resumes where it stopped.
// - Reset (rst_n low, synchronous): ring and gathering state cleared, output
//   empty, start marker back to 0xA5. No clearing pass; the slot memory is
//   only read where a stored frame was written.
// - APB port: start marker at byte address 0, write in the access phase,
//   pready tied high. Write only while the block is idle.
module checksum_frame_receiver_queue_core #(
  parameter int FRAME_BYTES = 13,
  parameter int QUEUE_SLOTS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [7:0]                    in_rx_byte,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [2:0]                    out_status,
  output logic [7:0]                    out_data_byte,
  output logic                          out_last,
  output logic                          out_link_active,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfrq_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  cfrq_pkg::ctrl_cmd_t  cmd;
  cfrq_pkg::dp_status_t status;
  logic [7:0]           marker_r, marker_nxt;
  logic                 reg_sel;
  logic                 cfg_wr;

  // register index sits at paddr[2]; byte lanes below it are ignored
  assign reg_sel = (paddr[2] == cfrq_pkg::REG_START_MARKER);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {24'd0, marker_r} : 32'd0;

  assign marker_nxt = cfg_wr ? pwdata[7:0] : marker_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= cfrq_pkg::START_MARKER_RST;
    end else begin
      marker_r <= marker_nxt;
    end
  end

  cfrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cfrq_dp #(
    .FRAME_BYTES (FRAME_BYTES),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .start_marker    (marker_r),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_status      (out_status),
    .out_data_byte   (out_data_byte),
    .out_last        (out_last),
    .out_link_active (out_link_active)
  );

endmodule

@@ hw/rtl/cfrq_checker.sv @@
// cfrq_checker: port-level assertions for the frame receiver queue, with bind.
// Depends on cfrq_pkg; attaches to checksum_frame_receiver_queue_core.
module cfrq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [2:0] out_status,
  input logic [7:0] out_data_byte,
  input logic       out_last
);

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte)
      && $stable(out_status) && $stable(out_kind) && $stable(out_last))
    else $error("output transaction changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // data results carry status zero
  a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cfrq_pkg::KIND_DATA |-> out_status == cfrq_pkg::ST_ACCEPTED)
    else $error("data result with nonzero status");

  // status results are single: last set, no data
  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cfrq_pkg::KIND_STATUS |-> out_last && out_data_byte == 8'd0)
    else $error("status result not last or carries data");

  // no new input transaction in the middle of a pop burst
  a_burst_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == cfrq_pkg::KIND_DATA && !out_last |-> in_stall)
    else $error("input taken during pop burst");

endmodule

bind checksum_frame_receiver_queue_core cfrq_checker u_cfrq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_status    (out_status),
  .out_data_byte (out_data_byte),
  .out_last      (out_last)
);

@@ tb/sv/checksum_frame_receiver_queue_core_tb.sv @@
`timescale 1ns / 100ps
// checksum_frame_receiver_queue_core_tb: self-checking bench for the frame receiver queue.
// Depends on cfrq_pkg and checksum_frame_receiver_queue_core only.
module checksum_frame_receiver_queue_core_tb;

  localparam int FRAME_BYTES   = 13;
  localparam int QUEUE_SLOTS   = 4;
  // a stored-frame pop keeps the block busy until its last byte is sent; allow margin
  localparam int SETTLE_CYCLES = FRAME_BYTES + 4;
  localparam int CYCLE_LIMIT   = 300000;
  localparam logic [cfrq_pkg::ADDR_W-1:0] MARKER_ADDR = {cfrq_pkg::REG_START_MARKER, 2'b00};

  // one result transaction as seen on the out_ channel
  typedef struct packed {
    logic       kind;
    logic [2:0] status;
    logic [7:0] data_byte;
    logic       last;
    logic       link;
  } rx_result_t;

  // directed script row; pinned rows carry a hand-written status result
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic       pinned;
    logic [2:0] status;
    logic       link;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [2:0]  out_status;
  logic [7:0]  out_data_byte;
  logic        out_last;
  logic        out_link_active;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [cfrq_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  checksum_frame_receiver_queue_core #(
    .FRAME_BYTES(FRAME_BYTES),
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_status     (out_status),
    .out_data_byte  (out_data_byte),
    .out_last       (out_last),
    .out_link_active(out_link_active),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the deframer: gathering buffer, running sum and the frame ring.
  // The ring keeps one slot free, so it is full at QUEUE_SLOTS-1 frames.
  // ---------------------------------------------------------------------------
  logic [7:0] shadow_marker;
  logic [7:0] gath_bytes [FRAME_BYTES];
  int         gath_count;
  logic [7:0] gath_sum;
  logic [7:0] ring_slots [QUEUE_SLOTS][FRAME_BYTES];
  int         ring_wr;
  int         ring_rd;

  rx_result_t due_results[$];   // results owed by the block, oldest first
  int         mismatch_count;
  int         items_sent;
  int         send_idle_pct;
  int         stall_pct;
  int         cycle_count;

  // link is sampled after the transaction has updated the state
  function automatic logic link_busy();
    return (ring_wr != ring_rd) || (gath_count != 0);
  endfunction

  // Advance the shadow by one accepted input transaction and queue what it owes.
  task automatic step_deframer(input logic cmd, input logic [7:0] b);
    rx_result_t r;
    logic [2:0] st;
    int         nxt;
    int         slot;
    r      = '0;
    r.kind = cfrq_pkg::KIND_STATUS;
    r.last = 1'b1;
    if (cmd == cfrq_pkg::CMD_BYTE) begin
      if (gath_count == 0 && b != shadow_marker) begin
        st = cfrq_pkg::ST_IGNORED;
      end else begin
        gath_bytes[gath_count] = b;
        gath_count++;
        if (gath_count < FRAME_BYTES) begin
          gath_sum += b;
          st = cfrq_pkg::ST_ACCEPTED;
        end else begin
          // closing byte: checksum, then ring space
          if (gath_sum != b) begin
            st = cfrq_pkg::ST_BADSUM;
          end else begin
            nxt = (ring_wr + 1) % QUEUE_SLOTS;
            if (nxt == ring_rd) begin
              st = cfrq_pkg::ST_FULL;
            end else begin
              for (int i = 0; i < FRAME_BYTES; i++) ring_slots[ring_wr][i] = gath_bytes[i];
              ring_wr = nxt;
              st = cfrq_pkg::ST_QUEUED;
            end
          end
          gath_count = 0;
          gath_sum   = '0;
        end
      end
      r.status = st;
      r.link   = link_busy();
      due_results.push_back(r);
    end else if (ring_wr == ring_rd) begin
      r.status = cfrq_pkg::ST_EMPTY;
      r.link   = link_busy();
      due_results.push_back(r);
    end else begin
      // pop of a stored frame: one data transaction per byte, same link flag
      slot    = ring_rd;
      ring_rd = (ring_rd + 1) % QUEUE_SLOTS;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        r.kind      = cfrq_pkg::KIND_DATA;
        r.data_byte = ring_slots[slot][i];
        r.last      = (i == FRAME_BYTES - 1);
        r.link      = link_busy();
        due_results.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, receiver stall and watchdog
  // ---------------------------------------------------------------------------
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result monitor: values read here are the ones present before this edge.
  always @(posedge clk) begin
    rx_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, 0);
      end else begin
        want = due_results.pop_front();
        if (out_kind !== want.kind)           report_mismatch("kind", out_kind, want.kind);
        if (out_status !== want.status)       report_mismatch("status", out_status, want.status);
        if (out_data_byte !== want.data_byte) report_mismatch("data_byte", out_data_byte,
                                                              want.data_byte);
        if (out_last !== want.last)           report_mismatch("last", out_last, want.last);
        if (out_link_active !== want.link)    report_mismatch("link_active", out_link_active,
                                                              want.link);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One input transaction: optional idle gap, then hold until accepted.
  task automatic send_item(input logic cmd, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= cmd;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_deframer(cmd, b);
    items_sent++;
  endtask

  // Stop sending and wait for every owed result, plus the burst latency.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the start marker, then a read back of the same register.
  task automatic set_start_marker(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MARKER_ADDR;
    pwdata  <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    shadow_marker = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {24'h0, value}) report_mismatch("prdata", prdata, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random phase: mostly well-formed frames with random payload, some with a
  // corrupted checksum, pops mixed in (also mid-frame), and line noise.
  task automatic run_random_phase(input int tx_idle, input int rx_stall,
                                  input logic [7:0] marker, input int pop_pct,
                                  input int quota);
    int         base;
    int         pick;
    logic [7:0] fb;
    logic [7:0] sum;
    logic       corrupt;
    quiesce();
    set_start_marker(marker);
    send_idle_pct = tx_idle;
    stall_pct     = rx_stall;
    base          = items_sent;
    while (items_sent - base < quota) begin
      pick = $urandom_range(99);
      if (pick < pop_pct) begin
        send_item(cfrq_pkg::CMD_POP, 8'($urandom));
      end else if (pick < pop_pct + 15) begin
        // noise on the idle line; rarely it happens to open a frame
        repeat ($urandom_range(1, 3)) begin
          fb = 8'($urandom);
          if (fb == marker && $urandom_range(9) != 0) fb = ~marker;
          send_item(cfrq_pkg::CMD_BYTE, fb);
        end
      end else begin
        corrupt = ($urandom_range(99) < 12);
        sum     = marker;
        send_item(cfrq_pkg::CMD_BYTE, marker);
        for (int i = 1; i < FRAME_BYTES - 1; i++) begin
          if ($urandom_range(99) < 4) send_item(cfrq_pkg::CMD_POP, 8'($urandom));
          fb   = 8'($urandom);
          sum += fb;
          send_item(cfrq_pkg::CMD_BYTE, fb);
        end
        if (corrupt) sum ^= 8'($urandom_range(1, 255));
        send_item(cfrq_pkg::CMD_BYTE, sum);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  script_row_t script [19];

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = cfrq_pkg::CMD_BYTE;
    in_rx_byte     = 8'h00;
    out_stall      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mismatch_count = 0;
    items_sent     = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    cycle_count    = 0;
    shadow_marker  = cfrq_pkg::START_MARKER_RST;
    gath_count     = 0;
    gath_sum       = '0;
    ring_wr        = 0;
    ring_rd        = 0;

    // Directed part, reset marker 0xA5. The good frame is built so its
    // checksum (0xA0) can be checked by hand.
    script = '{
      // pop of an empty ring
      '{cfrq_pkg::CMD_POP,  8'h00, 1'b1, cfrq_pkg::ST_EMPTY,    1'b0},
      // idle line, not the marker
      '{cfrq_pkg::CMD_BYTE, 8'h00, 1'b1, cfrq_pkg::ST_IGNORED,  1'b0},
      '{cfrq_pkg::CMD_BYTE, 8'hFF, 1'b1, cfrq_pkg::ST_IGNORED,  1'b0},
      // marker opens the frame
      '{cfrq_pkg::CMD_BYTE, 8'hA5, 1'b1, cfrq_pkg::ST_ACCEPTED, 1'b1},
      '{cfrq_pkg::CMD_BYTE, 8'hFF, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      '{cfrq_pkg::CMD_BYTE, 8'h00, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      '{cfrq_pkg::CMD_BYTE, 8'hFF, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      '{cfrq_pkg::CMD_BYTE, 8'h00, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      '{cfrq_pkg::CMD_BYTE, 8'h80, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      '{cfrq_pkg::CMD_BYTE, 8'h7F, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      '{cfrq_pkg::CMD_BYTE, 8'h01, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      '{cfrq_pkg::CMD_BYTE, 8'hFE, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      '{cfrq_pkg::CMD_BYTE, 8'h55, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      '{cfrq_pkg::CMD_BYTE, 8'hAA, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      '{cfrq_pkg::CMD_BYTE, 8'h00, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      // correct checksum, stored
      '{cfrq_pkg::CMD_BYTE, 8'hA0, 1'b1, cfrq_pkg::ST_QUEUED,   1'b1},
      // start a second frame
      '{cfrq_pkg::CMD_BYTE, 8'hA5, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      // pop streams the stored frame
      '{cfrq_pkg::CMD_POP,  8'hFF, 1'b0, cfrq_pkg::ST_ACCEPTED, 1'b0},
      // empty, but a frame is half built
      '{cfrq_pkg::CMD_POP,  8'h00, 1'b1, cfrq_pkg::ST_EMPTY,    1'b1}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[k]) begin
      send_item(script[k].cmd, script[k].rx_byte);
      if (script[k].pinned) begin
        void'(due_results.pop_back());
        due_results.push_back('{cfrq_pkg::KIND_STATUS, script[k].status, 8'h00, 1'b1,
                                script[k].link});
      end
    end

    // Each phase starts from a full drain, which is also the sender pause.
    // The first two phases pop rarely so the ring fills and frames get dropped.
    run_random_phase(0,  0,  8'h00,                      5,  40);
    run_random_phase(87, 0,  8'hFF,                      5,  12);
    run_random_phase(0,  87, 8'($urandom),               30, 8);
    run_random_phase(20, 20, cfrq_pkg::START_MARKER_RST, 30, 8);

    quiesce();
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cfrq_pkg.sv
hw/rtl/cfrq_ctrl.sv
hw/rtl/cfrq_dp.sv
hw/rtl/checksum_frame_receiver_queue_core.sv
hw/rtl/cfrq_checker.sv
tb/sv/checksum_frame_receiver_queue_core_tb.sv
